// ===== design/olt_pkg.sv =====
// olt_pkg: shared types, sizes and codes for the ordered list table
// used by olt_cell and ordered_list_table; no dependencies
`default_nettype none

package olt_pkg;

  localparam int DEPTH      = 16;
  localparam int ELEM_WIDTH = 32;
  localparam int POS_W      = 4;
  localparam int LEN_W      = 5;

  typedef logic [ELEM_WIDTH-1:0] elem_t;
  typedef logic [POS_W-1:0]      pos_t;
  typedef logic [LEN_W-1:0]      len_t;

  // opcodes
  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_READ = 3'd1;
  localparam logic [2:0] OP_FIND = 3'd2;
  localparam logic [2:0] OP_DEL  = 3'd3;
  localparam logic [2:0] OP_OVW  = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RANGE    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam len_t DEPTH_LEN = len_t'(DEPTH);

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic  add;
    logic  del;
    logic  ovw;
    pos_t  pos;
    elem_t value;
    len_t  count;
  } ctrl_t;

endpackage

`default_nettype wire

// ===== design/olt_cell.sv =====
// olt_cell: one list slot; shifts with its neighbors, compares and reads
// depends on olt_pkg
`default_nettype none

module olt_cell (
  input  wire logic          clk,
  input  wire olt_pkg::pos_t idx,
  input  wire olt_pkg::ctrl_t ctrl,
  input  wire olt_pkg::elem_t up_entry,
  input  wire olt_pkg::elem_t down_entry,
  output olt_pkg::elem_t     entry,
  output logic               match,
  output olt_pkg::elem_t     rd
);

  logic live;

  assign live = {1'b0, idx} < ctrl.count;

  always_ff @(posedge clk) begin
    // add moves every slot down, delete pulls slots from pos on up
    priority if (ctrl.add) begin
      entry <= up_entry;
    end else if (ctrl.del && idx >= ctrl.pos) begin
      entry <= down_entry;
    end else if (ctrl.ovw && idx == ctrl.pos) begin
      entry <= ctrl.value;
    end
    match <= live && (entry == ctrl.value);
    rd    <= (live && idx == ctrl.pos) ? entry : '0;
  end

endmodule

`default_nettype wire

// ===== design/ordered_list_table.sv =====
// ordered_list_table: top level, request sequencer and row of list cells
// depends on olt_pkg and olt_cell
//
// usage
//   in channel (in_valid/in_ready) carries one request word: opcode,
//   position and value. out channel (out_valid/out_ready) returns one result
//   word per request: status, read_value, found_position, length, empty_res
//   operations: add at front, read, find first match, delete, overwrite
// timing
//   the request is captured at the accepting edge; in the execute state all
//   cells shift, compare or read in parallel and register their flags; in
//   the result state the match flags are priority-encoded and the read word
//   is gathered into the output register, where out_valid rises
//   no new request is taken until the previous result is loaded; a new
//   request is taken while the previous result still waits
// stall
//   if out_ready is low the finished result sits in the output register;
//   a following request is processed but waits before loading its result
// reset
//   rst (synchronous) empties the list; slot contents are not cleared,
//   slots at or past the length are never observed
`default_nettype none

module ordered_list_table (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  opcode,
  input  wire logic [3:0]  position,
  input  wire logic [31:0] value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [31:0]      read_value,
  output logic [3:0]       found_position,
  output logic [4:0]       length,
  output logic             empty_res
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state;

  // captured request
  logic           [2:0] req_op;
  olt_pkg::pos_t        req_pos;
  olt_pkg::elem_t       req_val;

  olt_pkg::len_t  count;
  logic [1:0]     st_q;

  olt_pkg::ctrl_t ctrl;
  olt_pkg::elem_t entry [olt_pkg::DEPTH];
  olt_pkg::elem_t rd    [olt_pkg::DEPTH];
  logic [olt_pkg::DEPTH-1:0] match;

  logic in_range;
  logic full;

  assign in_ready = (state == S_IDLE);
  assign in_range = {1'b0, req_pos} < count;
  assign full     = (count == olt_pkg::DEPTH_LEN);

  // cell commands only fire in the execute cycle
  always_comb begin
    ctrl.add   = (state == S_EXEC) && (req_op == olt_pkg::OP_ADD) && !full;
    ctrl.del   = (state == S_EXEC) && (req_op == olt_pkg::OP_DEL) && in_range;
    ctrl.ovw   = (state == S_EXEC) && (req_op == olt_pkg::OP_OVW) && in_range;
    ctrl.pos   = req_pos;
    ctrl.value = req_val;
    ctrl.count = count;
  end

  // row of cells: slot 0 takes the new value on add, the last slot keeps
  // its own word on delete
  for (genvar i = 0; i < olt_pkg::DEPTH; i++) begin : g_cell
    olt_pkg::elem_t up_w;
    olt_pkg::elem_t down_w;
    if (i == 0) begin : g_first
      assign up_w = req_val;
    end else begin : g_mid
      assign up_w = entry[i-1];
    end
    if (i == olt_pkg::DEPTH - 1) begin : g_last
      assign down_w = entry[i];
    end else begin : g_inner
      assign down_w = entry[i+1];
    end
    olt_cell u_cell (
      .clk        (clk),
      .idx        (olt_pkg::pos_t'(i)),
      .ctrl       (ctrl),
      .up_entry   (up_w),
      .down_entry (down_w),
      .entry      (entry[i]),
      .match      (match[i]),
      .rd         (rd[i])
    );
  end

  // first match and gathered read word from registered cell outputs
  olt_pkg::pos_t  first_pos;
  olt_pkg::elem_t rd_or;

  always_comb begin
    first_pos = '0;
    for (int i = olt_pkg::DEPTH - 1; i >= 0; i--) begin
      if (match[i]) begin
        first_pos = olt_pkg::pos_t'(i);
      end
    end
  end

  always_comb begin
    rd_or = '0;
    for (int i = 0; i < olt_pkg::DEPTH; i++) begin
      rd_or = rd_or | rd[i];
    end
  end

  // status and length for the request in flight
  logic [1:0]    st_next;
  olt_pkg::len_t count_next;

  always_comb begin
    st_next    = olt_pkg::ST_OK;
    count_next = count;
    unique case (req_op)
      olt_pkg::OP_ADD: begin
        if (full) begin
          st_next = olt_pkg::ST_FULL;
        end else begin
          count_next = count + 1'b1;
        end
      end
      olt_pkg::OP_READ, olt_pkg::OP_OVW: begin
        if (!in_range) begin
          st_next = olt_pkg::ST_RANGE;
        end
      end
      olt_pkg::OP_DEL: begin
        if (in_range) begin
          count_next = count - 1'b1;
        end else begin
          st_next = olt_pkg::ST_RANGE;
        end
      end
      default: begin
        st_next = olt_pkg::ST_OK;
      end
    endcase
  end

  logic load_out;
  assign load_out = (state == S_DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          count <= count_next;
          state <= S_DONE;
        end
        S_DONE: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_op  <= opcode;
      req_pos <= position;
      req_val <= value;
    end
    if (state == S_EXEC) begin
      st_q <= st_next;
    end
    if (load_out) begin
      length         <= count;
      empty_res      <= (count == '0);
      if (req_op == olt_pkg::OP_FIND) begin
        status         <= (match != '0) ? olt_pkg::ST_OK : olt_pkg::ST_NOTFOUND;
        found_position <= (match != '0) ? first_pos : '0;
      end else begin
        status         <= st_q;
        found_position <= '0;
      end
      read_value <= (req_op == olt_pkg::OP_READ) ? rd_or : '0;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= olt_pkg::DEPTH_LEN)
    else $error("list length beyond depth");

  a_exec_done: assert property (@(posedge clk) disable iff (rst)
    state == S_EXEC |=> state == S_DONE)
    else $error("execute cycle not followed by result cycle");

  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && req_op == olt_pkg::OP_ADD && full) |=> count == olt_pkg::DEPTH_LEN)
    else $error("refused add changed the length");

  a_full_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == olt_pkg::ST_FULL) |-> length == olt_pkg::DEPTH_LEN)
    else $error("full status with short list");

endmodule

`default_nettype wire
